[rtl/core/stid_pkg.sv]
package stid_pkg;

  localparam int unsigned CapacityDefault = 16;
  localparam int unsigned ValueW          = 31;
  localparam int unsigned PosW            = 4;
  localparam int unsigned CountW          = 5;

  localparam logic OpInsert = 1'b0;
  localparam logic OpDelete = 1'b1;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StEmpty    = 2'd2,
    StNotFound = 2'd3
  } status_e;

  typedef struct packed {
    logic              opcode;
    logic [ValueW-1:0] value;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [PosW-1:0]   position;
    logic [CountW-1:0] count;
  } rsp_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] entry;
    logic              gt;  // empty or entry above the compared value
    logic              eq;  // valid and entry equal to the compared value
  } link_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic cmp_en;  // register compare flags against the request value
    logic ins_en;  // shift up from the insert point
    logic del_en;  // shift down from the first match
    logic is_del;  // select which boundary the cell reports
  } cell_ctrl_t;

endpackage

[rtl/core/stid_cell.sv]
module stid_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  stid_pkg::cell_ctrl_t            ctrl_i,
  input  logic [stid_pkg::ValueW-1:0]     value_i,
  input  stid_pkg::link_t                 left_i,
  input  stid_pkg::link_t                 right_i,
  output stid_pkg::link_t                 link_o,
  output logic                            bnd_o
);
  import stid_pkg::*;

  logic              valid_q, valid_d;
  logic [ValueW-1:0] entry_q, entry_d;
  logic              gt_q, ge_q, eq_q;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.ins_en && gt_q) begin
      // Take the left neighbor's entry, or the new value at the insert point.
      valid_d = left_i.valid;
      entry_d = left_i.gt ? left_i.entry : value_i;
    end else if (ctrl_i.del_en && ge_q) begin
      valid_d = right_i.valid;
      entry_d = right_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      gt_q    <= 1'b0;
      ge_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.cmp_en) begin
        gt_q <= !valid_q || (entry_q > value_i);
        ge_q <= valid_q && (entry_q >= value_i);
        eq_q <= valid_q && (entry_q == value_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign link_o = '{valid: valid_q, entry: entry_q, gt: gt_q, eq: eq_q};
  assign bnd_o  = ctrl_i.is_del ? (eq_q && !left_i.eq) : (gt_q && !left_i.gt);

endmodule

[rtl/core/stid_pos_enc.sv]
module stid_pos_enc #(
  parameter int unsigned N = stid_pkg::CapacityDefault
) (
  input  logic [N-1:0]               onehot_i,
  output logic [stid_pkg::PosW-1:0]  pos_o,
  output logic                       hit_o
);
  import stid_pkg::*;

  always_comb begin
    pos_o = '0;
    for (int i = 0; i < int'(N); i++) begin
      pos_o = pos_o | (onehot_i[i] ? PosW'(i) : '0);
    end
  end

  assign hit_o = |onehot_i;

endmodule

[rtl/core/sorted_table_insert_delete.sv]
// Each request is handled in turn: all cells compare against the request value as it is
// accepted, then the chain shifts and the response register loads in the apply state.
// No new request is taken until the apply state is done.
// The response register stalls the apply cycle only while a response waits downstream.
// Reset (rst_ni low, asynchronous) empties the table and drops any response in flight.
module sorted_table_insert_delete #(
  parameter int unsigned CAPACITY = stid_pkg::CapacityDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  stid_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output stid_pkg::rsp_t out_rsp_o
);
  import stid_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_e;

  state_e            state_q;
  logic              op_q;
  logic [ValueW-1:0] value_q;
  logic [CntW-1:0]   cnt_q;
  logic              out_valid_q;
  rsp_t              out_rsp_q;

  link_t             links [CAPACITY];
  link_t             lefts [CAPACITY];
  link_t             rights[CAPACITY];
  logic [CAPACITY-1:0] bnd;
  cell_ctrl_t        ctrl;
  logic [ValueW-1:0] cell_value;

  logic              accept, apply, full, empty, hit;
  logic [PosW-1:0]   pos;
  logic [CntW+CountW-1:0] cnt_ext;

  // A request is taken only between operations; the compare happens on accept.
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign apply      = (state_q == ST_APPLY) && (!out_valid_q || out_ready_i);

  // Compare against the live request; shift in the held copy, since the sender
  // may already offer the next request during the apply cycle.
  assign cell_value = (state_q == ST_APPLY) ? value_q : in_req_i.value;

  // Fill level as the cells see it: first and last valid bits.
  assign full  = links[CAPACITY-1].valid;
  assign empty = !links[0].valid;

  assign ctrl = '{
    cmp_en: accept,
    ins_en: apply && (op_q == OpInsert) && !full,
    del_en: apply && (op_q == OpDelete) && hit,
    is_del: (op_q == OpDelete)
  };

  // Chain the cells; the ends see an always-valid left and an empty right.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign lefts[g] = '{valid: 1'b1, entry: '0, gt: 1'b0, eq: 1'b0};
    end else begin : g_mid_l
      assign lefts[g] = links[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign rights[g] = '{valid: 1'b0, entry: '0, gt: 1'b1, eq: 1'b0};
    end else begin : g_mid_r
      assign rights[g] = links[g+1];
    end

    stid_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .value_i (cell_value),
      .left_i  (lefts[g]),
      .right_i (rights[g]),
      .link_o  (links[g]),
      .bnd_o   (bnd[g])
    );
  end

  // Encode the one cell that marks the insert point or the first match.
  stid_pos_enc #(
    .N (CAPACITY)
  ) u_pos_enc (
    .onehot_i (bnd),
    .pos_o    (pos),
    .hit_o    (hit)
  );

  // Count field wraps to its width when the table is deeper than the field.
  always_comb begin
    cnt_ext = (CntW + CountW)'(cnt_q);
    if (ctrl.ins_en) begin
      cnt_ext = (CntW + CountW)'(cnt_q + CntW'(1));
    end else if (ctrl.del_en) begin
      cnt_ext = (CntW + CountW)'(cnt_q - CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OpInsert;
      value_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '{status: StOk, position: '0, count: '0};
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q    <= in_req_i.opcode;
            value_q <= in_req_i.value;
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (apply) begin
            out_valid_q        <= 1'b1;
            out_rsp_q.count    <= cnt_ext[CountW-1:0];
            out_rsp_q.position <= '0;
            if (op_q == OpInsert) begin
              if (full) begin
                out_rsp_q.status <= StFull;
              end else begin
                out_rsp_q.status   <= StOk;
                out_rsp_q.position <= pos;
                cnt_q              <= cnt_ext[CntW-1:0];
              end
            end else if (empty) begin
              out_rsp_q.status <= StEmpty;
            end else if (!hit) begin
              out_rsp_q.status <= StNotFound;
            end else begin
              out_rsp_q.status   <= StOk;
              out_rsp_q.position <= pos;
              cnt_q              <= cnt_ext[CntW-1:0];
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

[rtl/core/stid_checker.sv]
module stid_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_o,
  input  stid_pkg::req_t in_req_i,
  input  logic           out_valid_o,
  input  logic           out_ready_i,
  input  stid_pkg::rsp_t out_rsp_o
);
  import stid_pkg::*;

  // A waiting request holds.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_req_i))
    else $error("request changed while waiting");

  // A stalled response holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed while stalled");

  // One operation at a time: no request taken right after one was taken.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken during an operation");

  // Failed operations touch no position.
  a_fail_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != StOk) |-> out_rsp_o.position == '0)
    else $error("nonzero position on a failed operation");

  // Empty is reported only with a zero count.
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == StEmpty) |-> out_rsp_o.count == '0)
    else $error("empty status with nonzero count");

endmodule

bind sorted_table_insert_delete stid_checker u_stid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

[tb/tb.sv]
module tb;
  import stid_pkg::*;

  localparam int unsigned Capacity      = CapacityDefault;
  localparam int unsigned RandomItems   = 1600;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned DrainCycles   = 6;
  localparam int unsigned MaxReports    = 10;

  logic clk      = 1'b0;
  logic rst_n    = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_rsp;

  // Directed rows carry a hand-typed response where it is obvious.
  typedef struct {
    req_t req;
    logic typed;
    rsp_t rsp;
  } dir_row_t;

  // Shadow copy of the table, updated as each request is accepted.
  logic [ValueW-1:0] shadow_entries [Capacity];
  int unsigned       shadow_fill = 0;

  // Responses still owed by the block, oldest first.
  rsp_t rsp_due [$];

  // Hand-typed response for the request currently offered; moves with the payload.
  logic req_typed     = 1'b0;
  rsp_t req_typed_rsp = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        filling       = 1'b1;

  int unsigned fail_count   = 0;
  int unsigned report_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned n_insert     = 0;
  int unsigned n_delete     = 0;
  int unsigned status_hits [4] = '{0, 0, 0, 0};

  sorted_table_insert_delete #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Apply one request to the shadow table and return the response it owes.
  // Insert goes after every entry that is less than or equal to the value;
  // delete removes the lowest-indexed match.
  function automatic rsp_t sorted_apply(req_t r);
    rsp_t rsp;
    int   slot;
    int   k;
    rsp.status   = StOk;
    rsp.position = '0;
    rsp.count    = CountW'(shadow_fill);
    slot = 0;
    if (r.opcode == OpInsert) begin
      if (shadow_fill >= Capacity) begin
        rsp.status = StFull;
      end else begin
        while (slot < int'(shadow_fill) && shadow_entries[slot] <= r.value) slot++;
        for (k = int'(shadow_fill); k > slot; k--) shadow_entries[k] = shadow_entries[k-1];
        shadow_entries[slot] = r.value;
        shadow_fill++;
        rsp.position = PosW'(slot);
        rsp.count    = CountW'(shadow_fill);
      end
    end else begin
      if (shadow_fill == 0) begin
        rsp.status = StEmpty;
      end else begin
        while (slot < int'(shadow_fill) && shadow_entries[slot] != r.value) slot++;
        if (slot >= int'(shadow_fill)) begin
          rsp.status = StNotFound;
        end else begin
          for (k = slot; k + 1 < int'(shadow_fill); k++) begin
            shadow_entries[k] = shadow_entries[k+1];
          end
          shadow_fill--;
          rsp.position = PosW'(slot);
          rsp.count    = CountW'(shadow_fill);
        end
      end
    end
    return rsp;
  endfunction

  function automatic dir_row_t dir_row(logic op, logic [ValueW-1:0] v, logic typed,
                                       status_e st, int unsigned pos, int unsigned cnt);
    dir_row_t row;
    row.req.opcode   = op;
    row.req.value    = v;
    row.typed        = typed;
    row.rsp.status   = st;
    row.rsp.position = PosW'(pos);
    row.rsp.count    = CountW'(cnt);
    return row;
  endfunction

  // Random request. Drift between filling and draining so that the full and
  // empty cases recur; most values come from a small pool or from the table
  // itself so that equal entries and successful deletes are common.
  function automatic req_t pick_request();
    req_t        r;
    int unsigned roll;
    if (shadow_fill >= Capacity) filling = 1'b0;
    else if (shadow_fill == 0) filling = 1'b1;
    else if ($urandom_range(99) < 3) filling = ~filling;
    roll     = $urandom_range(99);
    r.opcode = (roll < (filling ? 70 : 30)) ? OpInsert : OpDelete;
    roll     = $urandom_range(99);
    if (r.opcode == OpDelete && shadow_fill > 0 && roll < 60) begin
      r.value = shadow_entries[$urandom_range(shadow_fill - 1)];
    end else if (roll < 75) begin
      r.value = ValueW'($urandom_range(12, 1));
    end else if (roll < 80) begin
      r.value = ($urandom_range(1) != 0) ? '1 : '0;
    end else begin
      r.value = ValueW'($urandom);
    end
    return r;
  endfunction

  // Offer one request: idle at random first, then hold valid and payload
  // until the block takes it. Valid stays high into the next call, so it is
  // only lowered when a gap actually follows.
  task automatic offer_request(req_t r, logic typed, rsp_t typed_rsp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req        <= r;
    req_typed     <= typed;
    req_typed_rsp <= typed_rsp;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every owed response has come back. Wait for the
  // next edge first so that the request just taken is already on the owed list.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rsp_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall at random at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Scoreboard: predict on every accepted request, check every accepted
  // response against the oldest prediction, and watch for a hung block.
  always @(posedge clk) begin : scoreboard
    rsp_t want;
    logic bad;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = sorted_apply(in_req);
        if (req_typed) want = req_typed_rsp;
        rsp_due.push_back(want);
        if (in_req.opcode == OpInsert) n_insert++;
        else n_delete++;
      end
      if (out_valid && out_ready) begin
        status_hits[out_rsp.status]++;
        if (rsp_due.size() == 0) begin
          fail_count++;
          if (report_count < MaxReports) begin
            report_count++;
            $display("ERROR: response with none owed: status %s position %0d count %0d",
                     out_rsp.status.name(), out_rsp.position, out_rsp.count);
          end
        end else begin
          want = rsp_due.pop_front();
          bad  = (out_rsp.status !== want.status) || (out_rsp.position !== want.position) ||
                 (out_rsp.count !== want.count);
          if (bad) begin
            fail_count++;
            if (report_count < MaxReports) begin
              report_count++;
              $display("ERROR: response mismatch: expected %s/%0d/%0d got %s/%0d/%0d",
                       want.status.name(), want.position, want.count,
                       out_rsp.status.name(), out_rsp.position, out_rsp.count);
            end
          end
        end
      end
      // Count cycles with no handshake on either side; end a hung run.
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("ERROR: no handshake for %0d cycles, %0d responses owed",
                   stall_cycles, rsp_due.size());
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t    dir_rows [$];
    int unsigned k;
    int unsigned phase;
    int unsigned per_phase;

    // Directed part: empty-table delete, extreme values, zero, equal values,
    // a miss, deletes of an equal value and of the top entry, then fill up, hit
    // full, delete the bottom entry and refill so that the largest value lands in the top slot.
    dir_rows.push_back(dir_row(OpDelete, 31'd5,         1'b1, StEmpty,    0, 0));
    dir_rows.push_back(dir_row(OpInsert, 31'h7FFF_FFFF, 1'b1, StOk,       0, 1));
    dir_rows.push_back(dir_row(OpInsert, 31'd0,         1'b1, StOk,       0, 2));
    dir_rows.push_back(dir_row(OpInsert, 31'd1,         1'b1, StOk,       1, 3));
    dir_rows.push_back(dir_row(OpInsert, 31'd1,         1'b0, StOk,       0, 0));
    dir_rows.push_back(dir_row(OpDelete, 31'd2,         1'b1, StNotFound, 0, 4));
    dir_rows.push_back(dir_row(OpDelete, 31'd1,         1'b0, StOk,       0, 0));
    dir_rows.push_back(dir_row(OpDelete, 31'h7FFF_FFFF, 1'b0, StOk,       0, 0));
    for (k = 0; k < Capacity - 2; k++) begin
      dir_rows.push_back(dir_row(OpInsert,
                                 ValueW'(k[0] ? 31'h5555_5555 - k : 31'h2AAA_AAAA + k),
                                 1'b0, StOk, 0, 0));
    end
    dir_rows.push_back(dir_row(OpInsert, 31'h5555_5555, 1'b1, StFull,     0, Capacity));
    dir_rows.push_back(dir_row(OpDelete, 31'd0,         1'b0, StOk,       0, 0));
    dir_rows.push_back(dir_row(OpInsert, 31'h7FFF_FFFF, 1'b0, StOk,       0, 0));

    // Hold reset low, then release it on a clock edge.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase order: slow receiver, then slow sender, then no idling at all.
    per_phase = RandomItems / 3;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        foreach (dir_rows[i]) offer_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
        wait_drained();
      end
      for (k = 0; k < per_phase; k++) begin
        offer_request(pick_request(), 1'b0, '0);
        // Now and then let the pipeline run dry mid-phase.
        if ($urandom_range(99) == 0) wait_drained();
      end
      wait_drained();
    end

    // Let any stray response show up before the verdict.
    repeat (DrainCycles) @(posedge clk);

    $display("Run covered %0d inserts and %0d deletes across three idling mixes.",
             n_insert, n_delete);
    $display("Responses seen: ok %0d, full %0d, empty %0d, not found %0d; %0d mismatches.",
             status_hits[StOk], status_hits[StFull], status_hits[StEmpty],
             status_hits[StNotFound], fail_count);
    if (fail_count == 0 && rsp_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sorted_table_insert_delete.f]
rtl/core/stid_pkg.sv
rtl/core/stid_cell.sv
rtl/core/stid_pos_enc.sv
rtl/core/sorted_table_insert_delete.sv
rtl/core/stid_checker.sv
tb/tb.sv
